FILE: rtl/dnms_pkg.sv
// Shared types, constants and sigmoid table builder for the dense neuron MAC unit.
`timescale 1ns / 1ps

package dnms_pkg;

  localparam int unsigned SIG_DEPTH_DEF = 256;
  localparam int unsigned NEURON_W      = 10;
  localparam int unsigned ACC_W         = 48;
  localparam int unsigned QIN_W         = 16;
  localparam int unsigned BIAS_W        = 32;
  localparam int unsigned PROD_W        = 32;
  localparam int unsigned ACT_OUT_W     = 16;
  // Clamped sum covers [-8, 8) in Q8.24, i.e. 28 bits once offset to unsigned.
  localparam int unsigned SPAN_W        = 28;

  typedef logic signed [QIN_W-1:0]   q412_t;
  typedef logic signed [BIAS_W-1:0]  bias_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [ACT_OUT_W-1:0]      act_out_t;
  typedef logic [NEURON_W-1:0]       neuron_t;
  typedef logic [SPAN_W-1:0]         span_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam acc_t SUM_HI  = 48'sd134217727;
  localparam acc_t SUM_LO  = -48'sd134217728;

  // 48-bit add, saturating to the signed range.
  function automatic acc_t sat_add(input acc_t a, input acc_t b);
    logic [ACC_W:0] r;
    r = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (r[ACC_W] != r[ACC_W-1]) begin
      return r[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return acc_t'(r[ACC_W-1:0]);
  endfunction

  // Clamp to [-2^27, 2^27-1] and offset by 2^27.
  function automatic span_t clamp_span(input acc_t s);
    span_t u;
    if (s > SUM_HI) begin
      u = '1;
    end else if (s < SUM_LO) begin
      u = '0;
    end else begin
      u = {~s[SPAN_W-1], s[SPAN_W-2:0]};
    end
    return u;
  endfunction

  // Shift-subtract long division; only evaluated while building the table.
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] dv);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= dv) begin
        r    = r - dv;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid at x_k = -8 + 16k/d: Taylor e^-|x|/16, squared four times, then 1/(1+e^-x).
  function automatic act_out_t sig_entry(input int unsigned k, input int unsigned d);
    logic [63:0] dd;
    logic [63:0] twok;
    logic [63:0] diff;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] v;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] y;
    longint      sm;
    dd   = 64'(d);
    twok = 64'(k) << 1;
    diff = (twok >= dd) ? (twok - dd) : (dd - twok);
    t    = long_div(diff << 31, dd);
    term = 64'h1_0000_0000;
    sm   = longint'(term);
    for (int n = 1; n <= 15; n++) begin
      term = long_div((term * t) >> 32, 64'(n));
      if ((n % 2) == 1) sm = sm - longint'(term);
      else              sm = sm + longint'(term);
    end
    if (sm < 0) sm = 0;
    v = 64'(sm) >> 1;
    if (v > (64'd1 << 31)) v = 64'd1 << 31;
    for (int i = 0; i < 4; i++) begin
      v = (v * v) >> 31;
    end
    e   = v;
    den = (64'd1 << 31) + e;
    if (twok >= dd) y = long_div((64'd1 << 47) + (den >> 1), den);
    else            y = long_div((e << 16) + (den >> 1), den);
    if (y > 64'd65535) y = 64'd65535;
    return y[ACT_OUT_W-1:0];
  endfunction

endpackage

FILE: rtl/dense_neuron_mac_sigmoid_unit.sv
// Dense layer neuron: streaming MAC with bias, clamp, quantize and sigmoid table lookup.
// A word with last_of_row set passes stage 1, the row sum, clamp and table index stages, then the output register.
// Throughput: one input word per cycle while in_stall is low; the MAC loop closes on the accumulator register.
// Non-last words are absorbed while a result waits, unless a last word is held in stage 1; only last words go on.
// Reset (rst_n, synchronous, active low) clears the accumulator, neuron index and all valids.
// The sigmoid table is a constant built at elaboration, no fill time after reset.
`timescale 1ns / 1ps

module dense_neuron_mac_sigmoid_unit #(
  parameter int unsigned SIGMOID_TABLE_DEPTH = dnms_pkg::SIG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dnms_pkg::q412_t    in_weight,
  input  dnms_pkg::q412_t    in_activation_in,
  input  dnms_pkg::bias_t    in_bias,
  input  logic               in_last_of_row,
  output logic               out_valid,
  input  logic               out_stall,
  output dnms_pkg::act_out_t out_activation_out,
  output dnms_pkg::neuron_t  out_neuron_index
);
  import dnms_pkg::*;

  localparam int unsigned IW = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int unsigned DW = $clog2(SIGMOID_TABLE_DEPTH + 1);
  localparam int unsigned PW = SPAN_W + DW;

  typedef act_out_t sig_rom_t [SIGMOID_TABLE_DEPTH];

  function automatic sig_rom_t build_rom();
    sig_rom_t r;
    for (int unsigned k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin
      r[k] = sig_entry(k, SIGMOID_TABLE_DEPTH);
    end
    return r;
  endfunction

  localparam sig_rom_t SIG_ROM = build_rom();

  // stage 1: product
  logic     v1_r;
  prod_t    prod1_r;
  bias_t    bias1_r;
  logic     last1_r;
  // accumulator and neuron index
  acc_t     acc_r;
  acc_t     acc_nxt;
  acc_t     acc_sum;
  neuron_t  row_cnt_r;
  // stage 2: unbiased row sum
  logic     v2_r;
  acc_t     sum2_r;
  bias_t    bias2_r;
  neuron_t  tag2_r;
  // stage 3: clamped, offset sum
  logic     v3_r;
  span_t    span3_r;
  neuron_t  tag3_r;
  // stage 4: table index
  logic     v4_r;
  logic [IW-1:0] idx4_r;
  neuron_t  tag4_r;
  // output register
  logic     out_valid_r;
  act_out_t act_out_r;
  neuron_t  nidx_out_r;

  logic     rdy_o, rdy4, rdy3, rdy2, rdy1, mv1;
  prod_t    prod_nxt;
  span_t    span_nxt;
  logic [PW-1:0] qprod;

  assign rdy_o = !out_valid_r || !out_stall;
  assign rdy4  = !v4_r || rdy_o;
  assign rdy3  = !v3_r || rdy4;
  assign rdy2  = !v2_r || rdy3;
  // non-last words drain into the accumulator without waiting downstream
  assign mv1   = v1_r && (!last1_r || rdy2);
  assign rdy1  = !v1_r || mv1;
  assign in_stall = !rdy1;

  assign prod_nxt = in_weight * in_activation_in;
  assign acc_sum  = sat_add(acc_r, ACC_W'(prod1_r));
  assign span_nxt = clamp_span(sat_add(sum2_r, ACC_W'(bias2_r)));
  // idx = floor(span * D / 2^28), always below D
  assign qprod    = {{DW{1'b0}}, span3_r} * PW'(SIGMOID_TABLE_DEPTH);

  always_comb begin
    acc_nxt = acc_r;
    if (mv1) begin
      acc_nxt = last1_r ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      row_cnt_r   <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (rdy1)  v1_r        <= in_valid;
      if (rdy2)  v2_r        <= mv1 && last1_r;
      if (rdy3)  v3_r        <= v2_r;
      if (rdy4)  v4_r        <= v3_r;
      if (rdy_o) out_valid_r <= v4_r;
      if (mv1 && last1_r && rdy2) row_cnt_r <= row_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      prod1_r <= prod_nxt;
      bias1_r <= in_bias;
      last1_r <= in_last_of_row;
    end
    if (mv1 && last1_r && rdy2) begin
      sum2_r  <= acc_sum;
      bias2_r <= bias1_r;
      tag2_r  <= row_cnt_r;
    end
    if (v2_r && rdy3) begin
      span3_r <= span_nxt;
      tag3_r  <= tag2_r;
    end
    if (v3_r && rdy4) begin
      idx4_r <= qprod[SPAN_W +: IW];
      tag4_r <= tag3_r;
    end
    if (v4_r && rdy_o) begin
      act_out_r  <= SIG_ROM[idx4_r];
      nidx_out_r <= tag4_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_activation_out = act_out_r;
  assign out_neuron_index   = nidx_out_r;

endmodule

FILE: rtl/dnms_checker.sv
// Port-level checker for the dense neuron MAC unit, bound to the top level.
`timescale 1ns / 1ps

module dnms_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_last_of_row,
  input logic               out_valid,
  input logic               out_stall,
  input dnms_pkg::act_out_t out_activation_out,
  input dnms_pkg::neuron_t  out_neuron_index
);
  import dnms_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [3:0] pend_r;
  neuron_t    exp_idx_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // rows closed at the input but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      exp_idx_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(in_acc && in_last_of_row) - 4'(out_acc);
      if (out_acc) exp_idx_r <= exp_idx_r + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_activation_out)
                               && $stable(out_neuron_index))
    else $error("result word changed while stalled");

  a_only_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result word without a closed row");

  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_neuron_index == exp_idx_r)
    else $error("neuron index out of sequence");

  a_absorb_non_last: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 4'd0 |-> !in_stall)
    else $error("input stalled with no row in flight");

endmodule

bind dense_neuron_mac_sigmoid_unit dnms_checker u_dnms_checker (.*);

FILE: tb/dense_neuron_checker.sv
// Channel monitor for the dense neuron unit: predicts each result and compares it on arrival.
`timescale 1ns / 1ps

module dense_neuron_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  dnms_pkg::q412_t    in_weight,
  input  dnms_pkg::q412_t    in_activation_in,
  input  dnms_pkg::bias_t    in_bias,
  input  logic               in_last_of_row,
  input  logic               out_valid,
  input  logic               out_stall,
  input  dnms_pkg::act_out_t out_activation_out,
  input  dnms_pkg::neuron_t  out_neuron_index,
  output int                 fail_count,
  output int                 pending_count
);
  import dnms_pkg::*;

  localparam int unsigned LUT_DEPTH = SIG_DEPTH_DEF;
  localparam longint      ACC_TOP   = (64'sd1 <<< 47) - 1;
  localparam longint      ACC_BOT   = -(64'sd1 <<< 47);
  localparam longint      SPAN_TOP  = 64'sd134217727;
  localparam longint      SPAN_BOT  = -64'sd134217728;

  typedef struct packed {
    act_out_t act;
    neuron_t  idx;
  } neuron_result_t;

  act_out_t       sig_lut [LUT_DEPTH];
  longint         dot_acc;
  neuron_t        neuron_ctr;
  neuron_result_t expected_results[$];
  neuron_result_t oldest;
  int             mismatches;

  // Sigmoid at x = -8 + 16k/D via e^-|x|/16 series, squared four times.
  function automatic act_out_t sigmoid_point(input int unsigned k);
    longint unsigned d, twok, span_abs, t, term, v, e, den, y;
    longint          series;
    d    = LUT_DEPTH;
    twok = 64'(k) << 1;
    span_abs = (twok >= d) ? twok - d : d - twok;
    t    = (span_abs << 31) / d;
    term = 64'd1 << 32;
    series = longint'(term);
    for (int n = 1; n <= 15; n++) begin
      term = ((term * t) >> 32) / 64'(n);
      if (n % 2 == 1) series = series - longint'(term);
      else            series = series + longint'(term);
    end
    if (series < 0) series = 0;
    v = 64'(series) >> 1;
    if (v > (64'd1 << 31)) v = 64'd1 << 31;
    for (int i = 0; i < 4; i++) v = (v * v) >> 31;
    e   = v;
    den = (64'd1 << 31) + e;
    if (twok >= d) y = ((64'd1 << 47) + den / 2) / den;
    else           y = ((e << 16) + den / 2) / den;
    if (y > 64'd65535) y = 64'd65535;
    return y[15:0];
  endfunction

  function automatic longint acc_clip(input longint v);
    if (v > ACC_TOP) return ACC_TOP;
    if (v < ACC_BOT) return ACC_BOT;
    return v;
  endfunction

  task automatic mac_predict(input q412_t w, input q412_t a, input bias_t b, input logic is_last);
    longint         s;
    longint         lut_idx;
    neuron_result_t r;
    dot_acc = acc_clip(dot_acc + longint'(w) * longint'(a));
    if (is_last) begin
      s = acc_clip(dot_acc + longint'(b));
      if (s > SPAN_TOP) s = SPAN_TOP;
      if (s < SPAN_BOT) s = SPAN_BOT;
      lut_idx = ((s - SPAN_BOT) * longint'(LUT_DEPTH)) >>> 28;
      if (lut_idx >= LUT_DEPTH) lut_idx = LUT_DEPTH - 1;
      r.act = sig_lut[lut_idx];
      r.idx = neuron_ctr;
      expected_results.push_back(r);
      neuron_ctr = neuron_ctr + 1'b1;
      dot_acc = 0;
    end
  endtask

  initial begin
    for (int k = 0; k < LUT_DEPTH; k++) sig_lut[k] = sigmoid_point(k);
    dot_acc       = 0;
    neuron_ctr    = '0;
    mismatches    = 0;
    fail_count    = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      dot_acc    = 0;
      neuron_ctr = '0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        mac_predict(in_weight, in_activation_in, in_bias, in_last_of_row);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word act=%h idx=%0d", $time,
                   out_activation_out, out_neuron_index);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          if (out_activation_out !== oldest.act) begin
            $display("%0t: activation_out expected %h actual %h", $time,
                     oldest.act, out_activation_out);
            mismatches++;
          end
          if (out_neuron_index !== oldest.idx) begin
            $display("%0t: neuron_index expected %0d actual %0d", $time,
                     oldest.idx, out_neuron_index);
            mismatches++;
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_results.size();
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the dense neuron unit: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb;
  import dnms_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int RANDOM_WORDS = 428;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCKS} stall_mode_t;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  q412_t       in_weight        = '0;
  q412_t       in_activation_in = '0;
  bias_t       in_bias          = '0;
  logic        in_last_of_row   = 1'b0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  act_out_t    out_activation_out;
  neuron_t     out_neuron_index;

  int          fail_count;
  int          pending_count;
  int          burst_left = 0;
  int          gap;
  int          sent;
  int          row_len;
  stall_mode_t stall_mode  = STALL_NONE;
  logic [7:0]  stall_timer = '0;

  dense_neuron_mac_sigmoid_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_weight         (in_weight),
    .in_activation_in  (in_activation_in),
    .in_bias           (in_bias),
    .in_last_of_row    (in_last_of_row),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_activation_out(out_activation_out),
    .out_neuron_index  (out_neuron_index)
  );

  dense_neuron_checker neuron_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_weight         (in_weight),
    .in_activation_in  (in_activation_in),
    .in_bias           (in_bias),
    .in_last_of_row    (in_last_of_row),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_activation_out(out_activation_out),
    .out_neuron_index  (out_neuron_index),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver stall pattern: a new random mode is drawn each time stall_timer runs out.
  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode  <= stall_mode_t'($urandom_range(0, 3));
      stall_timer <= 8'($urandom_range(20, 120));
    end else begin
      stall_timer <= stall_timer - 1'b1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= stall_timer[3];
    endcase
  end

  function automatic q412_t rand_q412();
    case ($urandom_range(0, 3))
      0:       return q412_t'($urandom);
      3: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return 16'sh1000;
          default: return '0;
        endcase
      end
      default: return q412_t'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  function automatic bias_t rand_bias();
    case ($urandom_range(0, 3))
      0:       return bias_t'($urandom);
      3:       return bias_t'($urandom_range(0, 1 << 21) - (1 << 20));
      default: return bias_t'($urandom_range(0, 1 << 28) - (1 << 27));
    endcase
  endfunction

  // One word per call; bursts of random length, random gaps between them.
  task automatic send_word(input q412_t w, input q412_t a, input bias_t b, input logic lr);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_weight        <= w;
    in_activation_in <= a;
    in_bias          <= b;
    in_last_of_row   <= lr;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes and clamp edges
    send_word(16'sh7fff, 16'sh7fff, '0, 1'b1);
    send_word(16'sh8000, 16'sh7fff, '0, 1'b1);
    send_word(16'sh8000, 16'sh8000, 32'sh8000_0000, 1'b1);
    send_word('0, '0, '0, 1'b1);
    send_word('0, '0, 32'sd134217727, 1'b1);
    send_word('0, '0, 32'sd134217728, 1'b1);
    send_word('0, '0, -32'sd134217728, 1'b1);
    send_word('0, '0, -32'sd134217729, 1'b1);
    send_word('0, '0, 32'sh7fff_ffff, 1'b1);
    send_word('0, '0, 32'shffff_ffff, 1'b1);
    // One quantization step is 2^20 in Q8.24
    send_word('0, '0, -32'sd134217728 + 32'sd1048576, 1'b1);
    send_word('0, '0, -32'sd134217728 + 32'sd1048575, 1'b1);
    send_word('0, '0, 32'sd1048576, 1'b1);
    send_word('0, '0, -32'sd1, 1'b1);
    // Bias on non-last words is ignored
    send_word(16'sh1000, 16'sh1000, 32'sh7fff_ffff, 1'b0);
    send_word(16'sh1000, 16'she000, '0, 1'b1);
    send_word(16'sh1000, 16'sh1000, 32'sh8000_0000, 1'b0);
    send_word(16'sh1000, 16'sh1000, 32'sh8000_0000, 1'b0);
    send_word(16'sh1000, 16'sh1000, 32'sh7fff_ffff, 1'b0);
    send_word(16'sh0800, 16'sh1000, -32'sd16777216, 1'b1);
    send_word(16'sh7fff, 16'sh8000, 32'sh7fff_ffff, 1'b1);
    send_word(16'shffff, 16'shffff, '0, 1'b1);

    // Random rows of mixed length
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (int i = 0; i < row_len; i++) begin
        send_word(rand_q412(), rand_q412(), rand_bias(), (i == row_len - 1));
        sent++;
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dnms_pkg.sv
rtl/dense_neuron_mac_sigmoid_unit.sv
rtl/dnms_checker.sv
tb/dense_neuron_checker.sv
tb/tb.sv
